### rtl/rwfr_pkg.sv
package rwfr_pkg;

    localparam int REGISTER_COUNT = 64;
    localparam int REG_IDX_W      = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

    localparam logic [7:0] FRAME_HEADER = 8'h55;
    localparam logic [2:0] POS_LAST     = 3'd5;

    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_GOOD = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    // queued request kinds
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_GOOD = 2'd2;
    localparam logic [1:0] OP_BAD  = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [15:0] data;
    } t_op;

endpackage

### rtl/rwfr_front.sv
module rwfr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_command,
    input  logic [7:0]        i_rx_byte,
    input  logic [15:0]       i_read_addr,
    input  logic              i_full,
    output logic              o_ready,
    output logic              o_push,
    output rwfr_pkg::t_op     o_op
);
    import rwfr_pkg::*;

    logic [2:0]  r_pos;
    logic [2:0]  n_pos;
    logic [7:0]  r_sum;
    logic [7:0]  n_sum;
    logic        r_hdr_ok;
    logic        n_hdr_ok;
    logic [15:0] r_addr;
    logic [15:0] n_addr;
    logic [15:0] r_data;
    logic [15:0] n_data;
    logic        w_accept;
    logic        w_last;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;
    // a position past the last byte cannot occur; it closes the frame anyway
    assign w_last   = (r_pos >= POS_LAST);

    always_comb begin
        o_op.addr = r_addr;
        o_op.data = r_data;
        if (i_command) begin
            o_op.kind = OP_READ;
            o_op.addr = i_read_addr;
        end else if (w_last) begin
            o_op.kind = (r_hdr_ok && (r_sum == i_rx_byte)) ? OP_GOOD : OP_BAD;
        end else begin
            o_op.kind = OP_NONE;
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_hdr_ok = r_hdr_ok;
        n_addr   = r_addr;
        n_data   = r_data;
        if (w_accept && !i_command) begin
            if (w_last) begin
                n_pos    = 3'd0;
                n_sum    = 8'd0;
                n_hdr_ok = 1'b0;
            end else begin
                n_pos = r_pos + 3'd1;
                n_sum = r_sum + i_rx_byte;
                case (r_pos)
                    3'd0:    n_hdr_ok = (i_rx_byte == FRAME_HEADER);
                    3'd1:    n_addr[15:8] = i_rx_byte;
                    3'd2:    n_addr[7:0]  = i_rx_byte;
                    3'd3:    n_data[15:8] = i_rx_byte;
                    3'd4:    n_data[7:0]  = i_rx_byte;
                    default: n_pos = r_pos;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 3'd0;
            r_sum    <= 8'd0;
            r_hdr_ok <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_hdr_ok <= n_hdr_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_data <= n_data;
    end

endmodule

### rtl/rwfr_fifo.sv
module rwfr_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rwfr_pkg::t_op     i_op,
    input  logic              i_pop,
    output rwfr_pkg::t_op     o_op,
    output logic              o_full,
    output logic              o_empty
);
    import rwfr_pkg::*;

    t_op               r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_op    = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/rwfr_back.sv
module rwfr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rwfr_pkg::t_op     i_op,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [15:0]       o_read_data
);
    import rwfr_pkg::*;

    logic [15:0]               r_mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] r_written;
    logic [15:0]               r_mem_q;
    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic [1:0]                n_status;
    logic                      r_use_mem;
    logic                      w_in_range;
    logic [REG_IDX_W-1:0]      w_idx;
    logic                      w_wr;

    assign o_pop      = !i_empty && (!r_out_valid || i_ready);
    assign w_in_range = ({1'b0, i_op.addr} < 17'(REGISTER_COUNT));
    assign w_idx      = REG_IDX_W'(i_op.addr);
    assign w_wr       = o_pop && (i_op.kind == OP_GOOD) && w_in_range;

    always_comb begin
        unique case (i_op.kind)
            OP_GOOD: n_status = STATUS_GOOD;
            OP_BAD:  n_status = STATUS_BAD;
            default: n_status = STATUS_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_idx] <= i_op.data;
        end
        if (o_pop) begin
            r_mem_q <= r_mem[w_idx];
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr) begin
                r_written[w_idx] <= 1'b1;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status  <= n_status;
            r_use_mem <= (i_op.kind == OP_READ) && w_in_range && r_written[w_idx];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_read_data = r_use_mem ? r_mem_q : 16'd0;

endmodule

### rtl/register_write_frame_receiver.sv
// Accepted requests are queued, then popped into the result registers. Throughput: one
// request per cycle while the four-entry queue is not full; it decouples intake from result
// stalls. The register store is one 16-bit memory write or registered read per request.
// Reset (synchronous, active low) clears frame position, checksum, queue and output valid,
// and marks every register as unwritten so the whole store reads as zero at once.
module register_write_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] rx_byte, [23:8] read_addr
    input  logic        i_s_tuser,   // [0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [1:0] frame_status, [17:2] read_data, [23:18] zero
);
    import rwfr_pkg::*;

    t_op         w_push_op;
    t_op         w_head_op;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    logic [1:0]  w_status;
    logic [15:0] w_read_data;

    rwfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_command   (i_s_tuser),
        .i_rx_byte   (i_s_tdata[7:0]),
        .i_read_addr (i_s_tdata[23:8]),
        .i_full      (w_full),
        .o_ready     (o_s_tready),
        .o_push      (w_push),
        .o_op        (w_push_op)
    );

    rwfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_op    (w_head_op),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    rwfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_head_op),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_status    (w_status),
        .o_read_data (w_read_data)
    );

    assign o_m_tdata = {6'd0, w_read_data, w_status};

endmodule
